[hdl/stt_pkg.sv]
package stt_pkg;

  localparam int unsigned LINE_BITS_DEF   = 21;
  localparam int unsigned COLUMN_BITS_DEF = 17;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  localparam int unsigned KIND_W   = 5;
  localparam int unsigned VALUE_W  = 63;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PREFIX_W = 40;
  localparam int unsigned MAX_RES  = 3;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LINE  = 4'd2,
    M_BLOCK = 4'd3,
    M_BSTAR = 4'd4,
    M_NUM   = 4'd5,
    M_WORD  = 4'd6,
    M_EQ    = 4'd7,
    M_BANG  = 4'd8,
    M_LT    = 4'd9,
    M_GT    = 4'd10
  } mode_e;

  localparam logic [KIND_W-1:0] K_NUMBER = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] K_KW0    = 5'd2;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd10;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd11;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd12;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd13;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd14;
  localparam logic [KIND_W-1:0] K_EQEQ   = 5'd15;
  localparam logic [KIND_W-1:0] K_BANG   = 5'd16;
  localparam logic [KIND_W-1:0] K_NE     = 5'd17;
  localparam logic [KIND_W-1:0] K_LT     = 5'd18;
  localparam logic [KIND_W-1:0] K_GT     = 5'd19;
  localparam logic [KIND_W-1:0] K_LE     = 5'd20;
  localparam logic [KIND_W-1:0] K_GE     = 5'd21;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd22;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd23;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd24;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd25;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd26;
  localparam logic [KIND_W-1:0] K_END    = 5'd27;
  localparam logic [KIND_W-1:0] K_BAD    = 5'd28;
  localparam logic [KIND_W-1:0] K_OVER   = 5'd29;

  // keywords: let if else while print input true false
  localparam logic [PREFIX_W-1:0] KW_TEXT [8] = '{
    40'h00_006c_6574, 40'h00_0000_6966, 40'h00_656c_7365, 40'h77_6869_6c65,
    40'h70_7269_6e74, 40'h69_6e70_7574, 40'h00_7472_7565, 40'h66_616c_7365
  };
  localparam logic [LEN_W-1:0] KW_LEN [8] = '{
    16'd3, 16'd2, 16'd4, 16'd5, 16'd5, 16'd5, 16'd4, 16'd5
  };

  function automatic logic [KIND_W-1:0] word_kind(logic [PREFIX_W-1:0] prefix,
                                                  logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) k = K_KW0 + KIND_W'(i);
    end
    return k;
  endfunction

endpackage

[hdl/stt_lexer.sv]
module stt_lexer #(
  parameter int unsigned LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned RW = stt_pkg::KIND_W + stt_pkg::VALUE_W + LINE_BITS + COLUMN_BITS
                              + OFFSET_BITS + stt_pkg::LEN_W + stt_pkg::BYTE_W + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [stt_pkg::BYTE_W-1:0]        byte_i,
  input  logic                              present_i,
  input  logic                              end_i,
  output logic [1:0]                        res_n_o,
  output logic [RW-1:0]                     res_o [stt_pkg::MAX_RES]
);

  localparam int unsigned LB = LINE_BITS;
  localparam int unsigned CB = COLUMN_BITS;
  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned LW = stt_pkg::LEN_W;
  localparam int unsigned VW = stt_pkg::VALUE_W;
  localparam int unsigned KW = stt_pkg::KIND_W;
  localparam int unsigned PW = stt_pkg::PREFIX_W;

  localparam logic [LB-1:0] LINE_TOP = {1'b1, {(LB-1){1'b0}}};
  localparam logic [CB-1:0] COL_TOP  = {1'b1, {(CB-1){1'b0}}};
  localparam logic [OB-1:0] OFF_TOP  = {OB{1'b1}};
  localparam logic [LW-1:0] LEN_TOP  = {LW{1'b1}};
  localparam logic [LB-1:0] LINE_ONE = LB'(1);
  localparam logic [CB-1:0] COL_ONE  = CB'(1);

  stt_pkg::mode_e mode_q, mode_d;
  logic [LB-1:0] cur_line_q, cur_line_d, st_line_q, st_line_d;
  logic [CB-1:0] cur_col_q, cur_col_d, st_col_q, st_col_d;
  logic [OB-1:0] cur_off_q, cur_off_d, st_off_q, st_off_d;
  logic [VW-1:0] acc_q, acc_d;
  logic [PW-1:0] prefix_q, prefix_d;
  logic [LW-1:0] wlen_q, wlen_d;
  logic          err_q, err_d;

  logic          a_v, b_v, e1_v, e2_v;
  logic [RW-1:0] a_r, b_r, e1_r, e2_r;
  logic          restart;
  logic          is_blank, is_digit, is_alpha, is_word;
  logic [3:0]    digit;
  logic [VW+3:0] acc_x10;

  function automatic logic [RW-1:0] pack(logic [KW-1:0] kind, logic [VW-1:0] value,
                                         logic [LB-1:0] line, logic [CB-1:0] col,
                                         logic [OB-1:0] off, logic [LW-1:0] len,
                                         logic [stt_pkg::BYTE_W-1:0] bad, logic last);
    return {kind, value, line, col, off, len, bad, last};
  endfunction

  function automatic logic fin_valid(stt_pkg::mode_e m);
    return m == stt_pkg::M_NUM || m == stt_pkg::M_WORD || m == stt_pkg::M_SLASH ||
           m == stt_pkg::M_EQ || m == stt_pkg::M_BANG || m == stt_pkg::M_LT ||
           m == stt_pkg::M_GT;
  endfunction

  function automatic logic [RW-1:0] fin_pack(stt_pkg::mode_e m, logic [LB-1:0] sl,
                                             logic [CB-1:0] sc, logic [OB-1:0] so,
                                             logic [VW-1:0] acc, logic [LW-1:0] wl,
                                             logic [PW-1:0] pre);
    logic [KW-1:0] k;
    logic [VW-1:0] v;
    logic [LW-1:0] l;
    k = stt_pkg::K_SLASH;
    v = '0;
    l = LW'(1);
    case (m)
      stt_pkg::M_NUM: begin
        k = stt_pkg::K_NUMBER;
        v = acc;
        l = wl;
      end
      stt_pkg::M_WORD: begin
        k = stt_pkg::word_kind(pre, wl);
        l = wl;
      end
      stt_pkg::M_EQ:   k = stt_pkg::K_ASSIGN;
      stt_pkg::M_BANG: k = stt_pkg::K_BANG;
      stt_pkg::M_LT:   k = stt_pkg::K_LT;
      stt_pkg::M_GT:   k = stt_pkg::K_GT;
      default:         k = stt_pkg::K_SLASH;
    endcase
    return pack(k, v, sl, sc, so, l, '0, 1'b0);
  endfunction

  function automatic logic [KW-1:0] dbl_kind(stt_pkg::mode_e m);
    logic [KW-1:0] k;
    case (m)
      stt_pkg::M_EQ:   k = stt_pkg::K_EQEQ;
      stt_pkg::M_BANG: k = stt_pkg::K_NE;
      stt_pkg::M_LT:   k = stt_pkg::K_LE;
      default:         k = stt_pkg::K_GE;
    endcase
    return k;
  endfunction

  assign is_blank = byte_i == 8'h20 || byte_i == 8'h09 || byte_i == 8'h0d || byte_i == 8'h0a;
  assign is_digit = byte_i >= 8'h30 && byte_i <= 8'h39;
  assign is_alpha = (byte_i >= 8'h61 && byte_i <= 8'h7a) || (byte_i >= 8'h41 && byte_i <= 8'h5a);
  assign is_word  = is_alpha || is_digit || byte_i == 8'h5f;
  assign digit    = byte_i[3:0];
  // acc * 10 + digit; anything at or above bit VW means overflow
  assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VW+4)'(digit);

  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    cur_off_d  = cur_off_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    st_off_d   = st_off_q;
    acc_d      = acc_q;
    prefix_d   = prefix_q;
    wlen_d     = wlen_q;
    err_d      = err_q;
    a_v = 1'b0; b_v = 1'b0; e1_v = 1'b0; e2_v = 1'b0;
    a_r = '0;   b_r = '0;   e1_r = '0;   e2_r = '0;
    restart = 1'b0;
    if (fire_i && !err_q && present_i) begin
      case (mode_q)
        stt_pkg::M_NUM: begin
          if (!is_digit) begin
            restart = 1'b1;
          end else if (|acc_x10[VW+3:VW]) begin
            b_v = 1'b1;
            b_r = pack(stt_pkg::K_OVER, '0, st_line_q, st_col_q, st_off_q,
                       (wlen_q == LEN_TOP) ? wlen_q : wlen_q + LW'(1), '0, 1'b1);
            err_d  = 1'b1;
            mode_d = stt_pkg::M_IDLE;
          end else begin
            acc_d = acc_x10[VW-1:0];
            if (wlen_q != LEN_TOP) wlen_d = wlen_q + LW'(1);
          end
        end
        stt_pkg::M_WORD: begin
          if (is_word) begin
            if (wlen_q < LW'(5)) prefix_d = {prefix_q[PW-9:0], byte_i};
            if (wlen_q != LEN_TOP) wlen_d = wlen_q + LW'(1);
          end else begin
            restart = 1'b1;
          end
        end
        stt_pkg::M_SLASH: begin
          if (byte_i == 8'h2f) mode_d = stt_pkg::M_LINE;
          else if (byte_i == 8'h2a) mode_d = stt_pkg::M_BLOCK;
          else restart = 1'b1;
        end
        stt_pkg::M_EQ, stt_pkg::M_BANG, stt_pkg::M_LT, stt_pkg::M_GT: begin
          if (byte_i == 8'h3d) begin
            b_v = 1'b1;
            b_r = pack(dbl_kind(mode_q), '0, st_line_q, st_col_q, st_off_q, LW'(2), '0, 1'b0);
            mode_d = stt_pkg::M_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        stt_pkg::M_LINE: begin
          if (byte_i == 8'h0a) mode_d = stt_pkg::M_IDLE;
        end
        stt_pkg::M_BLOCK: begin
          if (byte_i == 8'h2a) mode_d = stt_pkg::M_BSTAR;
        end
        stt_pkg::M_BSTAR: begin
          if (byte_i == 8'h2f) mode_d = stt_pkg::M_IDLE;
          else if (byte_i != 8'h2a) mode_d = stt_pkg::M_BLOCK;
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        // flush the pending token, then open a new one at this byte unless it is blank
        a_v = fin_valid(mode_q);
        a_r = fin_pack(mode_q, st_line_q, st_col_q, st_off_q, acc_q, wlen_q, prefix_q);
        mode_d = stt_pkg::M_IDLE;
        if (!is_blank) begin
          st_line_d = cur_line_q;
          st_col_d  = cur_col_q;
          st_off_d  = cur_off_q;
          if (is_digit) begin
            mode_d = stt_pkg::M_NUM;
            acc_d  = VW'(digit);
            wlen_d = LW'(1);
          end else if (is_alpha || byte_i == 8'h5f) begin
            mode_d   = stt_pkg::M_WORD;
            prefix_d = PW'(byte_i);
            wlen_d   = LW'(1);
          end else begin
            case (byte_i)
              8'h2f: mode_d = stt_pkg::M_SLASH;
              8'h3d: mode_d = stt_pkg::M_EQ;
              8'h21: mode_d = stt_pkg::M_BANG;
              8'h3c: mode_d = stt_pkg::M_LT;
              8'h3e: mode_d = stt_pkg::M_GT;
              8'h2b, 8'h2d, 8'h2a, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b: begin
                b_v = 1'b1;
                case (byte_i)
                  8'h2b:   b_r = pack(stt_pkg::K_PLUS, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h2d:   b_r = pack(stt_pkg::K_MINUS, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h2a:   b_r = pack(stt_pkg::K_STAR, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h28:   b_r = pack(stt_pkg::K_LPAREN, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h29:   b_r = pack(stt_pkg::K_RPAREN, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h7b:   b_r = pack(stt_pkg::K_LBRACE, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  8'h7d:   b_r = pack(stt_pkg::K_RBRACE, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                  default: b_r = pack(stt_pkg::K_SEMI, '0, cur_line_q, cur_col_q, cur_off_q,
                                      LW'(1), '0, 1'b0);
                endcase
              end
              default: begin
                b_v   = 1'b1;
                b_r   = pack(stt_pkg::K_BAD, '0, cur_line_q, cur_col_q, cur_off_q,
                             LW'(1), byte_i, 1'b1);
                err_d = 1'b1;
              end
            endcase
          end
        end
      end

      // advance position, saturating
      if (byte_i == 8'h0a) begin
        if (cur_line_q < LINE_TOP) cur_line_d = cur_line_q + LINE_ONE;
        cur_col_d = COL_ONE;
      end else if (cur_col_q < COL_TOP) begin
        cur_col_d = cur_col_q + COL_ONE;
      end
      if (cur_off_q != OFF_TOP) cur_off_d = cur_off_q + OB'(1);
    end

    if (fire_i && end_i) begin
      if (!err_q && !err_d) begin
        e1_v = fin_valid(mode_d);
        e1_r = fin_pack(mode_d, st_line_d, st_col_d, st_off_d, acc_d, wlen_d, prefix_d);
        e2_v = 1'b1;
        e2_r = pack(stt_pkg::K_END, '0, cur_line_d, cur_col_d, cur_off_d, '0, '0, 1'b1);
      end
      mode_d     = stt_pkg::M_IDLE;
      cur_line_d = LINE_ONE;
      cur_col_d  = COL_ONE;
      cur_off_d  = '0;
      st_line_d  = LINE_ONE;
      st_col_d   = COL_ONE;
      st_off_d   = '0;
      acc_d      = '0;
      prefix_d   = '0;
      wlen_d     = '0;
      err_d      = 1'b0;
    end
  end

  // pack the produced words in order into the first slots
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < stt_pkg::MAX_RES; i++) res_o[i] = '0;
    if (a_v) begin
      res_o[0] = a_r;
      n = 2'd1;
    end
    if (b_v) begin
      res_o[n] = b_r;
      n = n + 2'd1;
    end
    if (e1_v && n != 2'd3) begin
      res_o[n] = e1_r;
      n = n + 2'd1;
    end
    if (e2_v && n != 2'd3) begin
      res_o[n] = e2_r;
      n = n + 2'd1;
    end
    res_n_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= stt_pkg::M_IDLE;
      cur_line_q <= LINE_ONE;
      cur_col_q  <= COL_ONE;
      cur_off_q  <= '0;
      st_line_q  <= LINE_ONE;
      st_col_q   <= COL_ONE;
      st_off_q   <= '0;
      acc_q      <= '0;
      prefix_q   <= '0;
      wlen_q     <= '0;
      err_q      <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      cur_off_q  <= cur_off_d;
      st_line_q  <= st_line_d;
      st_col_q   <= st_col_d;
      st_off_q   <= st_off_d;
      acc_q      <= acc_d;
      prefix_q   <= prefix_d;
      wlen_q     <= wlen_d;
      err_q      <= err_d;
    end
  end

endmodule

[hdl/stt_out_queue.sv]
module stt_out_queue #(
  parameter int unsigned RW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    res_n_i,
  input  logic [RW-1:0] res_i [stt_pkg::MAX_RES],
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [RW-1:0] head_o,
  output logic [1:0]    count_o
);

  logic [RW-1:0] slot_q [stt_pkg::MAX_RES];
  logic [1:0]    cnt_q;
  logic          fire, pop;

  // take a new item when empty or once the last waiting word leaves this cycle
  assign in_ready_o  = cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready_i);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = slot_q[0];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (fire) begin
      cnt_q <= res_n_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_n_i != 2'd0) begin
      slot_q <= res_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

[hdl/source_text_tokenizer.sv]
// Streaming lexer for a small C-like language.
// Input channel (in_valid_i/in_ready_o): one byte of source per word, with
// byte_present_i (byte is real) and source_end_i (last word of this source).
// Output channel (out_valid_o/out_ready_i): one token per word with kind,
// number value, start line/column/offset, length, offending byte and run_last.
// A word produces zero to three tokens, all computed in the accept cycle and
// loaded into a three-entry result buffer with a single output port; the first
// appears in the cycle after acceptance. Throughput is one input word per cycle
// while each word yields at most one token and the receiver does not stall; a
// word that yields more holds in_ready_o low until all but its last have left.
// A new word is taken in the same cycle the last buffered token leaves.
// When the receiver stalls, the buffer holds its tokens and in_ready_o drops
// once it is not about to empty. After an error token the rest of the source
// is dropped up to its end word, which yields nothing and rearms the lexer.
// Reset clears the buffer and puts the lexer at line 1, column 1, offset 0.
module source_text_tokenizer #(
  parameter int unsigned LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [stt_pkg::BYTE_W-1:0]   source_byte_i,
  input  logic                         byte_present_i,
  input  logic                         source_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [stt_pkg::KIND_W-1:0]   token_kind_o,
  output logic [stt_pkg::VALUE_W-1:0]  number_value_o,
  output logic [LINE_BITS-1:0]         token_line_o,
  output logic [COLUMN_BITS-1:0]       token_column_o,
  output logic [OFFSET_BITS-1:0]       token_offset_o,
  output logic [stt_pkg::LEN_W-1:0]    token_length_o,
  output logic [stt_pkg::BYTE_W-1:0]   offending_byte_o,
  output logic                         run_last_o
);

  localparam int unsigned RW = stt_pkg::KIND_W + stt_pkg::VALUE_W + LINE_BITS + COLUMN_BITS
                               + OFFSET_BITS + stt_pkg::LEN_W + stt_pkg::BYTE_W + 1;

  logic          fire;
  logic [1:0]    res_n;
  logic [RW-1:0] res [stt_pkg::MAX_RES];
  logic [RW-1:0] head;
  logic [1:0]    count;

  assign fire = in_valid_i && in_ready_o;

  stt_lexer #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .RW          (RW)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (source_byte_i),
    .present_i (byte_present_i),
    .end_i     (source_end_i),
    .res_n_o   (res_n),
    .res_o     (res)
  );

  stt_out_queue #(
    .RW (RW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_n_i     (res_n),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head),
    .count_o     (count)
  );

  assign {token_kind_o, number_value_o, token_line_o, token_column_o, token_offset_o,
          token_length_o, offending_byte_o, run_last_o} = head;

  a_run_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o |->
      (token_kind_o == stt_pkg::K_END || token_kind_o == stt_pkg::K_BAD ||
       token_kind_o == stt_pkg::K_OVER))
    else $error("run_last on a non-final token");

  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (count == 2'd0 || (count == 2'd1 && out_ready_i)))
    else $error("input taken while buffer still holds words");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_n != 2'd0 |=> out_valid_o && count == $past(res_n))
    else $error("produced tokens not loaded");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == stt_pkg::K_END |-> run_last_o && token_length_o == '0)
    else $error("malformed end token");

endmodule
